// File: hw/rtl/serial_frame_receiver_assert.svh
// Assertion macros used by the frame receiver checker.
`ifndef SERIAL_FRAME_RECEIVER_ASSERT_SVH
`define SERIAL_FRAME_RECEIVER_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define SFR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define SFR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/sfr_pkg.sv
// Types and constants of the serial frame receiver.
`timescale 1ns / 1ps

package sfr_pkg;

  localparam int unsigned AddrWidth = 4;
  localparam int unsigned DataWidth = 32;

  // Register indexes (byte address = 4 * index)
  localparam logic [1:0] RegHdr1    = 2'd0;
  localparam logic [1:0] RegHdr2    = 2'd1;
  localparam logic [1:0] RegIdLimit = 2'd2;

  typedef enum logic [5:0] {
    PH_HUNT1 = 6'b000001,
    PH_HUNT2 = 6'b000010,
    PH_ID    = 6'b000100,
    PH_LEN   = 6'b001000,
    PH_DATA  = 6'b010000,
    PH_CHECK = 6'b100000
  } sfr_phase_e;

  typedef enum logic [1:0] {
    EV_PAYLOAD = 2'd0,
    EV_GOOD    = 2'd1,
    EV_BAD     = 2'd2
  } sfr_event_e;

  typedef struct packed {
    logic [7:0] hdr1;
    logic [7:0] hdr2;
    logic [8:0] id_limit;
  } sfr_cfg_t;

  typedef struct packed {
    logic       valid;
    sfr_event_e ev;
    logic [7:0] id;
    logic [7:0] index;
    logic [7:0] value;
    logic [7:0] length;
  } sfr_result_t;

endpackage

// File: hw/rtl/sfr_parser.sv
// Frame parser: phase, running sum and frame fields, one byte per step.
`timescale 1ns / 1ps

module sfr_parser (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic [7:0]           byte_i,
  input  sfr_pkg::sfr_cfg_t    cfg_i,
  output sfr_pkg::sfr_result_t res_o
);

  sfr_pkg::sfr_phase_e phase_q, phase_d;
  logic [7:0] sum_q, sum_d;
  logic [7:0] id_q, id_d;
  logic [7:0] len_q, len_d;
  logic [7:0] cnt_q, cnt_d;
  logic [7:0] cnt_inc;

  assign cnt_inc = cnt_q + 8'd1;

  always_comb begin
    phase_d = phase_q;
    sum_d   = sum_q;
    id_d    = id_q;
    len_d   = len_q;
    cnt_d   = cnt_q;
    res_o.valid  = 1'b0;
    res_o.ev     = sfr_pkg::EV_PAYLOAD;
    res_o.id     = id_q;
    res_o.index  = cnt_q;
    res_o.value  = byte_i;
    res_o.length = len_q;
    unique case (phase_q)
      sfr_pkg::PH_HUNT1: begin
        if (byte_i == cfg_i.hdr1) begin
          sum_d   = byte_i;
          id_d    = 8'd0;
          len_d   = 8'd0;
          cnt_d   = 8'd0;
          phase_d = sfr_pkg::PH_HUNT2;
        end
      end
      sfr_pkg::PH_HUNT2: begin
        if (byte_i == cfg_i.hdr2) begin
          sum_d   = sum_q + byte_i;
          phase_d = sfr_pkg::PH_ID;
        end else begin
          phase_d = sfr_pkg::PH_HUNT1;
        end
      end
      sfr_pkg::PH_ID: begin
        if ({1'b0, byte_i} < cfg_i.id_limit) begin
          id_d    = byte_i;
          sum_d   = sum_q + byte_i;
          phase_d = sfr_pkg::PH_LEN;
        end else begin
          phase_d = sfr_pkg::PH_HUNT1;
        end
      end
      sfr_pkg::PH_LEN: begin
        len_d   = byte_i;
        sum_d   = sum_q + byte_i;
        phase_d = (byte_i == 8'd0) ? sfr_pkg::PH_CHECK : sfr_pkg::PH_DATA;
      end
      sfr_pkg::PH_DATA: begin
        res_o.valid = 1'b1;
        sum_d = sum_q + byte_i;
        cnt_d = cnt_inc;
        if (cnt_inc >= len_q) begin
          phase_d = sfr_pkg::PH_CHECK;
        end
      end
      sfr_pkg::PH_CHECK: begin
        res_o.valid = 1'b1;
        res_o.ev    = (sum_q == byte_i) ? sfr_pkg::EV_GOOD : sfr_pkg::EV_BAD;
        res_o.index = 8'd0;
        phase_d     = sfr_pkg::PH_HUNT1;
      end
      default: begin
        phase_d = sfr_pkg::PH_HUNT1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= sfr_pkg::PH_HUNT1;
      sum_q   <= 8'd0;
      id_q    <= 8'd0;
      len_q   <= 8'd0;
      cnt_q   <= 8'd0;
    end else if (step_i) begin
      phase_q <= phase_d;
      sum_q   <= sum_d;
      id_q    <= id_d;
      len_q   <= len_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// File: hw/rtl/serial_frame_receiver.sv
// Top level of the serial frame receiver: input stage, parser, result stage, registers.
`timescale 1ns / 1ps

// Serial frame receiver. Takes one byte per transaction on the input channel and
// recognizes frames: header byte 1, header byte 2, message id, length, that many
// payload bytes, checksum (8-bit wrapping sum of all earlier frame bytes). Each
// payload byte leaves as a result with event 0 and its index; the checksum byte
// leaves as a frame-end result, event 1 (good) or 2 (bad), index 0, carrying the
// received checksum. Header mismatch or id >= limit silently returns to the hunt.
// Throughput is one byte per clock while the output is not stalled: a byte is
// registered, then parsed by a single level of compare/add logic into the result
// register, and both stages move every cycle when the output is not stalled.
// The input stalls only while the result register holds an untaken result.
// Registers (APB, byte address 4*index): 0 first header (reset 0x55),
// 1 second header (reset 0xAA), 2 id limit, 9 bits (reset 16). Write them only
// while the block is idle.
module serial_frame_receiver (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // byte input channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [7:0]                    rx_byte_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [1:0]                    event_res_o,
  output logic [7:0]                    msg_id_o,
  output logic [7:0]                    byte_index_o,
  output logic [7:0]                    byte_value_o,
  output logic [7:0]                    frame_length_o,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sfr_pkg::AddrWidth-1:0] paddr,
  input  logic [sfr_pkg::DataWidth-1:0] pwdata,
  output logic [sfr_pkg::DataWidth-1:0] prdata,
  output logic                          pready
);

  sfr_pkg::sfr_cfg_t    cfg_q;
  sfr_pkg::sfr_result_t res;
  logic [1:0]           reg_idx;
  logic                 cfg_wr;

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       fire;
  logic       in_accept;

  logic                out_valid_q;
  sfr_pkg::sfr_event_e out_ev_q;
  logic [7:0]          out_id_q;
  logic [7:0]          out_index_q;
  logic [7:0]          out_value_q;
  logic [7:0]          out_len_q;

  // ---------------------------------------------------------------- registers
  assign pready  = 1'b1;
  assign reg_idx = paddr[sfr_pkg::AddrWidth-1:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hdr1     <= 8'h55;
      cfg_q.hdr2     <= 8'hAA;
      cfg_q.id_limit <= 9'd16;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        sfr_pkg::RegHdr1:    cfg_q.hdr1     <= pwdata[7:0];
        sfr_pkg::RegHdr2:    cfg_q.hdr2     <= pwdata[7:0];
        sfr_pkg::RegIdLimit: cfg_q.id_limit <= pwdata[8:0];
        default: ;  // no register there
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      sfr_pkg::RegHdr1:    prdata = {24'd0, cfg_q.hdr1};
      sfr_pkg::RegHdr2:    prdata = {24'd0, cfg_q.hdr2};
      sfr_pkg::RegIdLimit: prdata = {23'd0, cfg_q.id_limit};
      default:             prdata = '0;
    endcase
  end

  // -------------------------------------------------------------- input stage
  // Parse the held byte whenever the result register is free or being taken.
  assign fire       = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !fire;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_byte_q <= rx_byte_i;
    end
  end

  // ------------------------------------------------------------------- parser
  sfr_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (fire),
    .byte_i (in_byte_q),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  // ------------------------------------------------------------- result stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= res.valid;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && res.valid) begin
      out_ev_q    <= res.ev;
      out_id_q    <= res.id;
      out_index_q <= res.index;
      out_value_q <= res.value;
      out_len_q   <= res.length;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign event_res_o    = out_ev_q;
  assign msg_id_o       = out_id_q;
  assign byte_index_o   = out_index_q;
  assign byte_value_o   = out_value_q;
  assign frame_length_o = out_len_q;

endmodule

// File: hw/rtl/sfr_checker.sv
// Port-level checks of the serial frame receiver, bound to the top level.
`timescale 1ns / 1ps
`include "serial_frame_receiver_assert.svh"

module sfr_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [1:0] event_res_o,
  input logic [7:0] msg_id_o,
  input logic [7:0] byte_index_o,
  input logic [7:0] byte_value_o,
  input logic [7:0] frame_length_o
);

  `SFR_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i,
    out_valid_o && $stable(event_res_o) && $stable(msg_id_o) &&
    $stable(byte_index_o) && $stable(byte_value_o) && $stable(frame_length_o),
    "stalled result changed")

  `SFR_ASSERT_NOW(a_event_code, out_valid_o,
    event_res_o == sfr_pkg::EV_PAYLOAD || event_res_o == sfr_pkg::EV_GOOD ||
    event_res_o == sfr_pkg::EV_BAD,
    "unknown event code")

  `SFR_ASSERT_NOW(a_index_range, out_valid_o && event_res_o == sfr_pkg::EV_PAYLOAD,
    byte_index_o < frame_length_o, "payload index beyond frame length")

  `SFR_ASSERT_NOW(a_end_index, out_valid_o && event_res_o != sfr_pkg::EV_PAYLOAD,
    byte_index_o == 8'd0, "frame end with nonzero index")

  `SFR_ASSERT_NOW(a_no_idle_stall, !out_valid_o, !in_stall_o,
    "input stalled while result stage empty")

endmodule

bind serial_frame_receiver sfr_checker u_sfr_checker (.*);

// File: tb/tb.sv
// Self-checking testbench for the serial frame receiver: byte driver, result monitor, parser predictor.
`timescale 1ns / 1ps

module tb;

  // Register index past the end of the map; writes there must be dropped
  localparam logic [1:0] RegSpare = 2'd3;

  localparam int DrainCycles   = 6;     // pipeline is two deep, give it a few more
  localparam int HoldCycles    = 80;    // long receiver hold-off, fills the pipe
  localparam int WatchdogLimit = 2000;  // cycles without any transaction
  localparam int MaxReports    = 30;

  // One expected result of the parser
  typedef struct packed {
    sfr_pkg::sfr_event_e ev;
    logic [7:0]          id;
    logic [7:0]          index;
    logic [7:0]          value;
    logic [7:0]          length;
  } frame_result_t;

  logic        clk_i;
  logic        rst_ni = 1'b0;

  // byte input channel
  logic        in_valid = 1'b0;
  logic [7:0]  rx_byte  = 8'h00;
  logic        in_stall_o;

  // result channel
  logic        out_stall = 1'b0;
  logic        out_valid_o;
  logic [1:0]  event_res_o;
  logic [7:0]  msg_id_o;
  logic [7:0]  byte_index_o;
  logic [7:0]  byte_value_o;
  logic [7:0]  frame_length_o;

  // configuration port
  logic                          psel    = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite  = 1'b0;
  logic [sfr_pkg::AddrWidth-1:0] paddr   = '0;
  logic [sfr_pkg::DataWidth-1:0] pwdata  = '0;
  logic [sfr_pkg::DataWidth-1:0] prdata;
  logic                          pready;

  serial_frame_receiver u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall_o),
    .rx_byte_i      (rx_byte),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall),
    .event_res_o    (event_res_o),
    .msg_id_o       (msg_id_o),
    .byte_index_o   (byte_index_o),
    .byte_value_o   (byte_value_o),
    .frame_length_o (frame_length_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // --------------------------------------------------------------------------
  // Shared testbench state
  // --------------------------------------------------------------------------
  logic [7:0]    pending_bytes[$];     // bytes waiting to be offered
  frame_result_t expected_results[$];  // predicted results, oldest first
  int            error_count  = 0;
  int            send_idle_pct  = 0;   // chance of a sender bubble per free slot
  int            recv_stall_pct = 0;   // chance of a stall per cycle
  bit            byte_taken   = 1'b0;  // input transaction at the last rising edge
  bit            hold_go      = 1'b0;
  bit            hold_done    = 1'b0;
  int            idle_cycles  = 0;
  logic [7:0]    gen_sum;              // running checksum of the frame being built

  // Predictor copy of the registers
  logic [7:0]    cfg_hdr1     = 8'd85;
  logic [7:0]    cfg_hdr2     = 8'd170;
  logic [8:0]    cfg_id_limit = 9'd16;

  // Predictor copy of the parser state
  sfr_pkg::sfr_phase_e parse_state = sfr_pkg::PH_HUNT1;
  logic [7:0]    frame_sum    = 8'd0;
  logic [7:0]    cur_id       = 8'd0;
  logic [7:0]    cur_len      = 8'd0;
  logic [7:0]    rx_count     = 8'd0;

  // --------------------------------------------------------------------------
  // Clock and reset (reset applied once, never again)
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
  end

  // --------------------------------------------------------------------------
  // Mismatch reporting: one line per failure, output capped
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (error_count < MaxReports) begin
      $display("%0t ERROR %s: got %0h, expected %0h", $time, what, got, want);
    end
    error_count++;
  endtask

  // --------------------------------------------------------------------------
  // Frame parser prediction, one call per accepted byte
  // --------------------------------------------------------------------------
  task automatic predict_byte(input logic [7:0] c);
    case (parse_state)
      sfr_pkg::PH_HUNT1: begin
        if (c == cfg_hdr1) begin
          frame_sum   = c;
          cur_id      = 8'd0;
          cur_len     = 8'd0;
          rx_count    = 8'd0;
          parse_state = sfr_pkg::PH_HUNT2;
        end
      end
      sfr_pkg::PH_HUNT2: begin
        // a wrong second header is not retried as a first header
        if (c == cfg_hdr2) begin
          frame_sum   = frame_sum + c;
          parse_state = sfr_pkg::PH_ID;
        end else begin
          parse_state = sfr_pkg::PH_HUNT1;
        end
      end
      sfr_pkg::PH_ID: begin
        if ({1'b0, c} < cfg_id_limit) begin
          cur_id      = c;
          frame_sum   = frame_sum + c;
          parse_state = sfr_pkg::PH_LEN;
        end else begin
          parse_state = sfr_pkg::PH_HUNT1;
        end
      end
      sfr_pkg::PH_LEN: begin
        cur_len     = c;
        frame_sum   = frame_sum + c;
        parse_state = (c == 8'd0) ? sfr_pkg::PH_CHECK : sfr_pkg::PH_DATA;
      end
      sfr_pkg::PH_DATA: begin
        expected_results.push_back('{sfr_pkg::EV_PAYLOAD, cur_id, rx_count, c, cur_len});
        frame_sum = frame_sum + c;
        rx_count  = rx_count + 8'd1;
        if (rx_count >= cur_len) parse_state = sfr_pkg::PH_CHECK;
      end
      sfr_pkg::PH_CHECK: begin
        expected_results.push_back('{(frame_sum == c) ? sfr_pkg::EV_GOOD : sfr_pkg::EV_BAD,
                                     cur_id, 8'd0, c, cur_len});
        parse_state = sfr_pkg::PH_HUNT1;
      end
      default: parse_state = sfr_pkg::PH_HUNT1;
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Input side: sample the handshake at the rising edge, drive at the falling
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    byte_taken = rst_ni && in_valid && !in_stall_o;
    if (byte_taken) predict_byte(rx_byte);
  end

  // Driver: holds a stalled byte, otherwise pulls the next one from the queue
  // unless a bubble is rolled. Valid never looks at the stall.
  always @(negedge clk_i) begin : drive_bytes
    logic       next_valid;
    logic [7:0] next_byte;
    next_valid = in_valid;
    next_byte  = rx_byte;
    if (!in_valid || byte_taken) begin
      next_valid = 1'b0;
      if (rst_ni && pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_valid = 1'b1;
        next_byte  = pending_bytes.pop_front();
      end
    end
    in_valid <= next_valid;
    rx_byte  <= next_byte;
  end

  // --------------------------------------------------------------------------
  // Output side: random stall plus one long hold-off, checked at the rising edge
  // --------------------------------------------------------------------------
  initial begin : receiver_hold
    wait (hold_go);
    repeat (HoldCycles) @(negedge clk_i);
    hold_done = 1'b1;
  end

  always @(negedge clk_i) begin
    out_stall <= (hold_go && !hold_done) || ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk_i) begin : check_results
    frame_result_t want;
    if (rst_ni && out_valid_o && !out_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result, event_res", 32'(event_res_o), 32'hx);
      end else begin
        want = expected_results.pop_front();
        if (event_res_o !== want.ev) begin
          report_mismatch("event_res", 32'(event_res_o), 32'(want.ev));
        end
        if (msg_id_o !== want.id) begin
          report_mismatch("msg_id", 32'(msg_id_o), 32'(want.id));
        end
        if (byte_index_o !== want.index) begin
          report_mismatch("byte_index", 32'(byte_index_o), 32'(want.index));
        end
        if (byte_value_o !== want.value) begin
          report_mismatch("byte_value", 32'(byte_value_o), 32'(want.value));
        end
        if (frame_length_o !== want.length) begin
          report_mismatch("frame_length", 32'(frame_length_o), 32'(want.length));
        end
      end
    end
  end

  // Watchdog: ends the run if neither channel moves for too long
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("serial_frame_receiver: mismatch");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Register access over the APB-style port
  // --------------------------------------------------------------------------
  task automatic apb_access(input bit wr, input logic [1:0] idx, input logic [31:0] data,
                            output logic [31:0] rdata);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = {idx, 2'b00};
    pwdata  = data;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata = prdata;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Write with random upper bits (must be masked off), then read back; the spare slot is only written
  task automatic cfg_write(input logic [1:0] idx, input logic [8:0] value);
    logic [31:0] noise;
    logic [31:0] rd;
    noise = $urandom();
    case (idx)
      sfr_pkg::RegHdr1: begin
        apb_access(1'b1, idx, {noise[31:8], value[7:0]}, rd);
        cfg_hdr1 = value[7:0];
        apb_access(1'b0, idx, 32'd0, rd);
        if (rd[7:0] !== cfg_hdr1) begin
          report_mismatch("first header readback", rd, 32'(cfg_hdr1));
        end
      end
      sfr_pkg::RegHdr2: begin
        apb_access(1'b1, idx, {noise[31:8], value[7:0]}, rd);
        cfg_hdr2 = value[7:0];
        apb_access(1'b0, idx, 32'd0, rd);
        if (rd[7:0] !== cfg_hdr2) begin
          report_mismatch("second header readback", rd, 32'(cfg_hdr2));
        end
      end
      sfr_pkg::RegIdLimit: begin
        apb_access(1'b1, idx, {noise[31:9], value}, rd);
        cfg_id_limit = value;
        apb_access(1'b0, idx, 32'd0, rd);
        if (rd[8:0] !== cfg_id_limit) begin
          report_mismatch("id limit readback", rd, 32'(cfg_id_limit));
        end
      end
      default: apb_access(1'b1, idx, noise, rd);  // no register there, nothing changes
    endcase
  endtask

  task automatic set_config(input logic [7:0] h1, input logic [7:0] h2, input logic [8:0] lim);
    cfg_write(sfr_pkg::RegHdr1, {1'b0, h1});
    cfg_write(sfr_pkg::RegHdr2, {1'b0, h2});
    cfg_write(sfr_pkg::RegIdLimit, lim);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus builders
  // --------------------------------------------------------------------------
  task automatic queue_byte(input logic [7:0] b);
    pending_bytes.push_back(b);
    gen_sum = gen_sum + b;
  endtask

  task automatic frame_head(input logic [7:0] id, input logic [7:0] len);
    gen_sum = 8'd0;
    queue_byte(cfg_hdr1);
    queue_byte(cfg_hdr2);
    queue_byte(id);
    queue_byte(len);
  endtask

  task automatic queue_checksum(input bit corrupt);
    logic [7:0] flip;
    flip = 8'($urandom_range(255, 1));
    pending_bytes.push_back(corrupt ? (gen_sum ^ flip) : gen_sum);
  endtask

  // Mostly well-formed frames with random content, plus broken frames and noise
  task automatic random_traffic(input int quota);
    int         queued;
    int         kind;
    int         len;
    int         cut;
    logic [7:0] id;
    queued = 0;
    while (queued < quota) begin
      kind = $urandom_range(99);
      len  = ($urandom_range(19) == 0) ? $urandom_range(40, 8) : $urandom_range(7);
      if (cfg_id_limit != 9'd0 && $urandom_range(9) != 0) begin
        id = 8'($urandom_range(cfg_id_limit - 9'd1));
      end else begin
        id = 8'($urandom_range(255));
      end
      if (kind < 70) begin
        frame_head(id, 8'(len));
        repeat (len) queue_byte(8'($urandom_range(255)));
        queue_checksum($urandom_range(6) == 0);
        queued += len + 5;
      end else if (kind < 80) begin
        // second header wrong
        gen_sum = 8'd0;
        queue_byte(cfg_hdr1);
        queue_byte(cfg_hdr2 ^ 8'($urandom_range(255, 1)));
        queued += 2;
      end else if (kind < 90) begin
        // frame cut short; whatever follows lands in its payload or checksum
        cut = $urandom_range(len);
        frame_head(id, 8'(len));
        repeat (cut) queue_byte(8'($urandom_range(255)));
        queued += cut + 4;
      end else begin
        repeat ($urandom_range(4, 1)) pending_bytes.push_back(8'($urandom_range(255)));
      end
    end
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  // Wait until every byte is taken and every result seen, then let the
  // pipeline settle (bytes that make no result may still be in flight)
  task automatic drain;
    @(posedge clk_i);
    while (pending_bytes.size() != 0 || in_valid || expected_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    wait (rst_ni);
    @(negedge clk_i);

    // Reset register values, no idling
    set_idling(0, 0);
    // wrong second header that equals the first header: not retried
    gen_sum = 8'd0;
    queue_byte(cfg_hdr1);
    queue_byte(cfg_hdr1);
    queue_byte(cfg_hdr2);
    // id right at the limit is dropped
    queue_byte(cfg_hdr1);
    queue_byte(cfg_hdr2);
    queue_byte(cfg_id_limit[7:0]);
    // zero length, largest legal id, good checksum
    frame_head(cfg_id_limit[7:0] - 8'd1, 8'd0);
    queue_checksum(1'b0);
    // payload extremes, bad checksum
    frame_head(8'h00, 8'd2);
    queue_byte(8'hFF);
    queue_byte(8'h00);
    queue_checksum(1'b1);
    // single payload byte, good checksum
    frame_head(8'h0A, 8'd1);
    queue_byte(8'h80);
    queue_checksum(1'b0);
    drain();

    // Random traffic under a long receiver hold-off: input must back up
    random_traffic(120);
    hold_go = 1'b1;
    drain();

    // All ids accepted, one maximum-length frame; sender bubbles
    set_config(8'h00, 8'hFF, 9'd256);
    set_idling(58, 0);
    frame_head(8'hFF, 8'd255);
    repeat (255) queue_byte(8'($urandom_range(255)));
    queue_checksum(1'b0);
    random_traffic(90);
    drain();

    // Only id zero passes; receiver stalls
    set_config(8'hFF, 8'h00, 9'd1);
    set_idling(0, 58);
    random_traffic(110);
    drain();

    // Random settings; both sides idle
    set_config(8'($urandom_range(255)), 8'($urandom_range(255)), 9'($urandom_range(256)));
    set_idling(31, 31);
    random_traffic(130);
    drain();

    // Equal header bytes, write to the unused slot must change nothing
    begin : equal_headers
      logic [7:0] hdr;
      hdr = 8'($urandom_range(255));
      set_config(hdr, hdr, 9'($urandom_range(256, 1)));
    end
    cfg_write(RegSpare, 9'($urandom_range(511)));
    set_idling(0, 0);
    random_traffic(80);
    drain();

    // Limit zero: every frame dies at its id byte
    set_config(8'($urandom_range(255)), 8'($urandom_range(255)), 9'd0);
    set_idling(31, 58);
    random_traffic(30);
    drain();

    if (error_count == 0) begin
      $display("serial_frame_receiver: match");
    end else begin
      $display("serial_frame_receiver: mismatch");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/sfr_pkg.sv
hw/rtl/sfr_parser.sv
hw/rtl/serial_frame_receiver.sv
hw/rtl/sfr_checker.sv
tb/tb.sv
